>>> rtl/kcl_pkg.sv
// Shared types, key map, event codes and reset values for the keypad combination lock.
package kcl_pkg;

  localparam int DIGIT_W = 4;

  localparam logic [DIGIT_W-1:0] EMPTY_DIGIT = 4'd10;
  localparam logic [3:0]         MISS_LIMIT  = 4'd15;

  localparam logic [15:0] BLOCK_SECONDS_RESET = 16'd10;
  localparam logic [3:0]  MAX_MISSES_RESET    = 4'd3;

  // Input command codes
  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Function keys, row-major key numbers
  localparam logic [4:0] KEY_CLEAR  = 5'd4;
  localparam logic [4:0] KEY_CHANGE = 5'd8;
  localparam logic [4:0] KEY_SET    = 5'd12;
  localparam logic [4:0] KEY_RESET  = 5'd13;
  localparam logic [4:0] KEY_SHOW   = 5'd15;
  localparam logic [4:0] KEY_OPEN   = 5'd16;

  // Configuration register indexes
  localparam logic CFG_BLOCK_SECONDS = 1'b0;
  localparam logic CFG_MAX_MISSES    = 1'b1;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_OPENED    = 3'd1,
    EV_CLOSED    = 3'd2,
    EV_WRONG     = 3'd3,
    EV_BLOCKED   = 3'd4,
    EV_UNBLOCKED = 3'd5
  } event_t;

  typedef struct packed {
    logic [15:0] block_seconds;
    logic [3:0]  max_misses;
  } cfg_t;

  typedef struct packed {
    logic               is_digit;
    logic [DIGIT_W-1:0] value;
  } key_digit_t;

  typedef struct packed {
    logic        door_open;
    logic        locked_out;
    logic        code_matched;
    logic        show_digits;
    logic [15:0] entry_digits;
    logic [2:0]  entry_count;
    logic [3:0]  miss_count;
    event_t      event_res;
  } result_t;

  // Decode a key number into a digit value
  function automatic key_digit_t key_digit(input logic [4:0] key);
    key_digit_t d;
    d.is_digit = 1'b1;
    case (key)
      5'd1:    d.value = 4'd1;
      5'd2:    d.value = 4'd2;
      5'd3:    d.value = 4'd3;
      5'd5:    d.value = 4'd4;
      5'd6:    d.value = 4'd5;
      5'd7:    d.value = 4'd6;
      5'd9:    d.value = 4'd7;
      5'd10:   d.value = 4'd8;
      5'd11:   d.value = 4'd9;
      5'd14:   d.value = 4'd0;
      default: begin
        d.is_digit = 1'b0;
        d.value    = 4'd0;
      end
    endcase
    return d;
  endfunction

endpackage

>>> rtl/kcl_engine.sv
// Lock state registers and the single-pass update for one key press or tick.
module kcl_engine #(
  parameter int CODE_DIGITS = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             command,
  input  logic [4:0]       key_code,
  input  kcl_pkg::cfg_t    cfg,
  output kcl_pkg::result_t result
);

  localparam int POS_W = $clog2(CODE_DIGITS + 1);
  localparam logic [POS_W-1:0] POS_FULL = POS_W'(CODE_DIGITS);

  logic [kcl_pkg::DIGIT_W-1:0] entry_buffer      [CODE_DIGITS];
  logic [kcl_pkg::DIGIT_W-1:0] entry_buffer_next [CODE_DIGITS];
  logic [kcl_pkg::DIGIT_W-1:0] stored_code       [CODE_DIGITS];
  logic [kcl_pkg::DIGIT_W-1:0] stored_code_next  [CODE_DIGITS];
  logic [POS_W-1:0] entry_position, entry_position_next;
  logic             match_flag, match_flag_next;
  logic             door_state, door_state_next;
  logic             show_flag, show_flag_next;
  logic [3:0]       misses, misses_next;
  logic             blocked_flag, blocked_flag_next;
  logic [15:0]      block_elapsed, block_elapsed_next;

  kcl_pkg::event_t     ev;
  kcl_pkg::key_digit_t kd;
  logic [POS_W-1:0]    pos_back;
  logic [15:0]         elapsed_inc;
  logic [3:0]          miss_inc;
  logic                same;
  logic [POS_W+2:0]    pos_wide;

  always_comb begin
    entry_buffer_next   = entry_buffer;
    stored_code_next    = stored_code;
    entry_position_next = entry_position;
    match_flag_next     = match_flag;
    door_state_next     = door_state;
    show_flag_next      = show_flag;
    misses_next         = misses;
    blocked_flag_next   = blocked_flag;
    block_elapsed_next  = block_elapsed;
    ev                  = kcl_pkg::EV_NONE;

    kd          = kcl_pkg::key_digit(key_code);
    pos_back    = (entry_position != '0) ? entry_position - 1'b1 : '0;
    elapsed_inc = block_elapsed + 16'd1;
    miss_inc    = (misses == kcl_pkg::MISS_LIMIT) ? misses : misses + 4'd1;
    same        = 1'b1;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if (entry_buffer[i] != stored_code[i]) same = 1'b0;
    end

    if (step) begin
      if (command == kcl_pkg::CMD_TICK) begin
        if (blocked_flag) begin
          if (elapsed_inc >= cfg.block_seconds) begin
            block_elapsed_next = '0;
            blocked_flag_next  = 1'b0;
            misses_next        = '0;
            ev                 = kcl_pkg::EV_UNBLOCKED;
          end else begin
            block_elapsed_next = elapsed_inc;
          end
        end
      end else if (!blocked_flag) begin
        if (kd.is_digit) begin
          // Drop digits once the buffer is full
          if (entry_position < POS_FULL) begin
            for (int i = 0; i < CODE_DIGITS; i++) begin
              if (entry_position == POS_W'(i)) entry_buffer_next[i] = kd.value;
            end
            entry_position_next = entry_position + 1'b1;
          end
        end else begin
          case (key_code)
            kcl_pkg::KEY_CLEAR: begin
              entry_position_next = pos_back;
              for (int i = 0; i < CODE_DIGITS; i++) begin
                if (pos_back == POS_W'(i)) entry_buffer_next[i] = kcl_pkg::EMPTY_DIGIT;
              end
              match_flag_next = 1'b0;
            end
            kcl_pkg::KEY_CHANGE: begin
              if (match_flag) begin
                for (int i = 0; i < CODE_DIGITS; i++) begin
                  entry_buffer_next[i] = kcl_pkg::EMPTY_DIGIT;
                end
                entry_position_next = '0;
              end
            end
            kcl_pkg::KEY_SET: begin
              if (match_flag) stored_code_next = entry_buffer;
            end
            kcl_pkg::KEY_RESET: begin
              for (int i = 0; i < CODE_DIGITS; i++) begin
                entry_buffer_next[i] = kcl_pkg::EMPTY_DIGIT;
              end
              entry_position_next = '0;
            end
            kcl_pkg::KEY_SHOW: begin
              show_flag_next = ~show_flag;
            end
            kcl_pkg::KEY_OPEN: begin
              entry_position_next = '0;
              if (same) begin
                misses_next = '0;
                if (!door_state) begin
                  match_flag_next = 1'b1;
                  door_state_next = 1'b1;
                  ev              = kcl_pkg::EV_OPENED;
                end else begin
                  match_flag_next = 1'b0;
                  door_state_next = 1'b0;
                  for (int i = 0; i < CODE_DIGITS; i++) begin
                    entry_buffer_next[i] = kcl_pkg::EMPTY_DIGIT;
                  end
                  ev = kcl_pkg::EV_CLOSED;
                end
              end else begin
                match_flag_next = 1'b0;
                misses_next     = miss_inc;
                for (int i = 0; i < CODE_DIGITS; i++) begin
                  entry_buffer_next[i] = kcl_pkg::EMPTY_DIGIT;
                end
                if (miss_inc >= cfg.max_misses) begin
                  blocked_flag_next  = 1'b1;
                  block_elapsed_next = '0;
                  ev                 = kcl_pkg::EV_BLOCKED;
                end else begin
                  ev = kcl_pkg::EV_WRONG;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  // Result reflects the state after this item
  always_comb begin
    pos_wide              = {3'b000, entry_position_next};
    result.door_open      = door_state_next;
    result.locked_out     = blocked_flag_next;
    result.code_matched   = match_flag_next;
    result.show_digits    = show_flag_next;
    result.entry_digits   = '0;
    for (int i = 0; i < 4; i++) begin
      if (i < CODE_DIGITS) result.entry_digits[4*i +: 4] = entry_buffer_next[i];
    end
    result.entry_count    = pos_wide[2:0];
    result.miss_count     = misses_next;
    result.event_res      = ev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CODE_DIGITS; i++) begin
        entry_buffer[i] <= kcl_pkg::EMPTY_DIGIT;
        stored_code[i]  <= '0;
      end
      entry_position <= '0;
      match_flag     <= 1'b0;
      door_state     <= 1'b0;
      show_flag      <= 1'b1;
      misses         <= '0;
      blocked_flag   <= 1'b0;
      block_elapsed  <= '0;
    end else if (step) begin
      entry_buffer   <= entry_buffer_next;
      stored_code    <= stored_code_next;
      entry_position <= entry_position_next;
      match_flag     <= match_flag_next;
      door_state     <= door_state_next;
      show_flag      <= show_flag_next;
      misses         <= misses_next;
      blocked_flag   <= blocked_flag_next;
      block_elapsed  <= block_elapsed_next;
    end
  end

endmodule

>>> rtl/keypad_combination_lock.sv
// Top level of the keypad combination lock: handshakes, configuration and result register.
//
//  channel  | valid/ready          | payload
//  ---------+----------------------+-------------------------------------------------
//  input    | in_valid/in_ready    | command, key_code
//  result   | out_valid/out_ready  | door_open, locked_out, code_matched, show_digits,
//           |                      | entry_digits, entry_count, miss_count, event_res
//  config   | cfg_valid/cfg_ready  | cfg_index (0 block_seconds, 1 max_misses), cfg_data
//
// One item per cycle sustained while out_ready accepts results; the result passes through
// the input register, then the single-pass update into the result register, before it is
// offered. A stall on out_ready holds the flow; otherwise the state update is one short
// combinational pass, so it does not limit the rate below one per cycle.
// Synchronous active-high reset empties the entry, zeroes the code and loads the
// configuration defaults (block 10 ticks, 3 misses).
// A stalled result holds the result register; the input register keeps one more item,
// after which in_ready drops until the result moves.
module keypad_combination_lock #(
  parameter int CODE_DIGITS = 4
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [4:0]  key_code,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        door_open,
  output logic        locked_out,
  output logic        code_matched,
  output logic        show_digits,
  output logic [15:0] entry_digits,
  output logic [2:0]  entry_count,
  output logic [3:0]  miss_count,
  output logic [2:0]  event_res,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  kcl_pkg::cfg_t    cfg;
  kcl_pkg::result_t result;
  kcl_pkg::result_t out_reg;

  logic       held_valid;
  logic       held_command;
  logic [4:0] held_key_code;
  logic       out_free;
  logic       step;

  // Result slot opens when empty or when its transfer happens now
  assign out_free  = !out_valid || out_ready;
  assign step      = held_valid && out_free;
  assign in_ready  = !held_valid || out_free;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_seconds <= kcl_pkg::BLOCK_SECONDS_RESET;
      cfg.max_misses    <= kcl_pkg::MAX_MISSES_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        kcl_pkg::CFG_BLOCK_SECONDS: cfg.block_seconds <= cfg_data;
        kcl_pkg::CFG_MAX_MISSES:    cfg.max_misses    <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // Input register: load on every input transfer, drop valid when consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (step) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_command  <= command;
      held_key_code <= key_code;
    end
  end

  kcl_engine #(
    .CODE_DIGITS(CODE_DIGITS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .command  (held_command),
    .key_code (held_key_code),
    .cfg      (cfg),
    .result   (result)
  );

  // Result register: hold while stalled, advance on each step
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_reg <= result;
    end
  end

  assign door_open    = out_reg.door_open;
  assign locked_out   = out_reg.locked_out;
  assign code_matched = out_reg.code_matched;
  assign show_digits  = out_reg.show_digits;
  assign entry_digits = out_reg.entry_digits;
  assign entry_count  = out_reg.entry_count;
  assign miss_count   = out_reg.miss_count;
  assign event_res    = out_reg.event_res;

endmodule
